### sv/dark_line_centroid_steering_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion macros for the dark-line centroid steering block.
// ----------------------------------------------------------------------------
`ifndef DARK_LINE_CENTROID_STEERING_TOP_DEFINES_SVH
`define DARK_LINE_CENTROID_STEERING_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define DLCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define DLCS_ASSERT_NEVER(lbl, expr, msg) \
   `DLCS_ASSERT(lbl, !(expr), msg)
`else
`define DLCS_ASSERT(lbl, prop, msg)
`define DLCS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### sv/dlcs_pkg.sv
// ----------------------------------------------------------------------------
// dlcs_pkg
// Types, register indexes and reset values of the centroid steering block.
// ----------------------------------------------------------------------------
package dlcs_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int QUEUE_DEPTH    = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_THRESHOLD   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEER_GAIN       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORWARD_SPEED    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_TURN_RATE = 3'd5;

   localparam logic [12:0]        RST_IMAGE_WIDTH      = 13'd640;
   localparam logic [12:0]        RST_IMAGE_HEIGHT     = 13'd480;
   localparam logic [7:0]         RST_DARK_THRESHOLD   = 8'd50;
   localparam logic [15:0]        RST_STEER_GAIN       = 16'd328;
   localparam logic [15:0]        RST_FORWARD_SPEED    = 16'd819;
   localparam logic signed [15:0] RST_SEARCH_TURN_RATE = 16'sd819;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic               line_found;
      logic [11:0]        centroid_x;
      logic signed [11:0] offset_error;
      logic [22:0]        dark_count;
      logic [15:0]        linear_speed;
      logic signed [23:0] angular_rate;
   } rsp_payload_type;

endpackage

### sv/dlcs_front.sv
// ----------------------------------------------------------------------------
// dlcs_front
// Pixel intake: raster position tracking, dark test and column accumulation.
// ----------------------------------------------------------------------------
module dlcs_front #(
   parameter int MAX_WIDTH  = dlcs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dlcs_pkg::MAX_HEIGHT_DEF,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT),
   localparam int NW = CW + RW + 1,
   localparam int SW = NW + CW
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dlcs_pkg::req_payload_type req_payload,
   input  logic [CW:0]              w_eff,
   input  logic [RW:0]              h_eff,
   input  logic [7:0]               dark_threshold,
   input  logic                     full,
   output logic                     push,
   output logic [SW+NW-1:0]         push_data
);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [NW-1:0] cnt_ff, cnt_in;

   logic          accept, row_end, frame_end, dark, in_region;
   logic [CW:0]   col_inc;
   logic [RW:0]   row_inc, band_top;
   logic [RW+2:0] h3;
   logic [SW-1:0] sum_add;
   logic [NW-1:0] cnt_add;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_inc   = {1'b0, col_ff} + {{CW{1'b0}}, 1'b1};
      row_inc   = {1'b0, row_ff} + {{RW{1'b0}}, 1'b1};
      row_end   = col_inc >= w_eff;
      frame_end = row_end && (row_inc >= h_eff);
      h3        = {2'b00, h_eff} + {1'b0, h_eff, 1'b0};
      band_top  = h3[RW+2:2];
      in_region = ({1'b0, row_ff} >= band_top) && ({1'b0, row_ff} < h_eff);
      dark      = (req_payload.red < dark_threshold) &&
                  (req_payload.green < dark_threshold) &&
                  (req_payload.blue < dark_threshold);
      if (in_region && dark) begin
         sum_add = sum_ff + SW'(col_ff);
         cnt_add = cnt_ff + {{(NW-1){1'b0}}, 1'b1};
      end else begin
         sum_add = sum_ff;
         cnt_add = cnt_ff;
      end

      col_in = col_ff;
      row_in = row_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_add;
            cnt_in = cnt_add;
            if (row_end) begin
               col_in = '0;
               row_in = row_inc[RW-1:0];
            end else begin
               col_in = col_inc[CW-1:0];
            end
         end
      end
   end

   assign push      = accept && frame_end;
   assign push_data = {sum_add, cnt_add};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### sv/dlcs_queue.sv
// ----------------------------------------------------------------------------
// dlcs_queue
// Short frame queue between pixel intake and the steering back end.
// ----------------------------------------------------------------------------
`include "dark_line_centroid_steering_top_defines.svh"

module dlcs_queue #(
   parameter int DEPTH  = dlcs_pkg::QUEUE_DEPTH,
   parameter int DATA_W = 8,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int LW = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]     level_ff, level_in;

   assign full      = level_ff == LW'(DEPTH);
   assign not_empty = level_ff != '0;
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + {{(LW-1){1'b0}}, 1'b1};
      end else if (pop && !push) begin
         level_in = level_ff - {{(LW-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   `DLCS_ASSERT(a_queue_no_overflow, push |-> !full, "frame pushed into full queue")
   `DLCS_ASSERT_NEVER(a_queue_level, level_ff > LW'(DEPTH), "queue level beyond depth")

endmodule

### sv/dlcs_back.sv
// ----------------------------------------------------------------------------
// dlcs_back
// Per-frame steering: centroid division, error, gain multiply, saturation.
// ----------------------------------------------------------------------------
`include "dark_line_centroid_steering_top_defines.svh"

module dlcs_back #(
   parameter int MAX_WIDTH  = dlcs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dlcs_pkg::MAX_HEIGHT_DEF,
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int RW  = $clog2(MAX_HEIGHT),
   localparam int NW  = CW + RW + 1,
   localparam int SW  = NW + CW,
   localparam int STW = $clog2(CW + 1),
   localparam int PRW = CW + 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       not_empty,
   input  logic [SW+NW-1:0]           pop_data,
   output logic                       pop,
   input  logic [CW-1:0]              half_width,
   input  logic [15:0]                steer_gain,
   input  logic [15:0]                forward_speed,
   input  logic signed [15:0]         search_turn_rate,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dlcs_pkg::rsp_payload_type  rsp_payload
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_ERR  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [SW-1:0]      rem_ff, rem_in, dsh_ff, dsh_in;
   logic [NW-1:0]      den_ff, den_in;
   logic [CW-1:0]      quo_ff, quo_in;
   logic [STW-1:0]     step_ff, step_in;
   logic signed [CW:0] err_ff, err_in;
   logic [CW-1:0]      mag_ff, mag_in;
   logic [PRW-1:0]     prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dlcs_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic               ge, found, err_pos, slot_free;
   logic signed [CW:0] diff;
   logic [63:0]        cen64, cnt64;
   logic signed [31:0] err32;
   logic [47:0]        p48;
   logic [43:0]        qv;
   logic [23:0]        qs, ang;
   dlcs_pkg::rsp_payload_type result;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ge   = rem_ff >= dsh_ff;
      diff = $signed({1'b0, quo_ff}) - $signed({1'b0, half_width});

      found   = den_ff != '0;
      err_pos = !err_ff[CW] && (err_ff != '0);
      cen64   = 64'(quo_ff);
      cnt64   = 64'(den_ff);
      err32   = 32'(err_ff);
      p48     = 48'(prod_ff) + 48'd8;
      qv      = p48[47:4];
      qs      = (qv > 44'd8388608) ? 24'h800000 : qv[23:0];
      if (err_pos) begin
         ang = -qs;
      end else begin
         ang = (qs > 24'h7FFFFF) ? 24'h7FFFFF : qs;
      end

      if (found) begin
         result.line_found   = 1'b1;
         result.centroid_x   = (cen64 > 64'd4095) ? 12'd4095 : cen64[11:0];
         if (err32 > 32'sd2047) begin
            result.offset_error = 12'sd2047;
         end else if (err32 < -32'sd2048) begin
            result.offset_error = -12'sd2048;
         end else begin
            result.offset_error = err32[11:0];
         end
         result.dark_count   = (cnt64 > 64'd8388607) ? 23'h7FFFFF : cnt64[22:0];
         result.linear_speed = forward_speed;
         result.angular_rate = ang;
      end else begin
         result.line_found   = 1'b0;
         result.centroid_x   = '0;
         result.offset_error = '0;
         result.dark_count   = '0;
         result.linear_speed = '0;
         result.angular_rate = {{8{search_turn_rate[15]}}, search_turn_rate};
      end

      state_in     = state_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      err_in       = err_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               pop      = 1'b1;
               rem_in   = pop_data[SW+NW-1:NW];
               den_in   = pop_data[NW-1:0];
               dsh_in   = SW'(pop_data[NW-1:0]) << (CW - 1);
               quo_in   = '0;
               step_in  = STW'(CW - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? rem_ff - dsh_ff : rem_ff;
            quo_in  = CW'({quo_ff, ge});
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - {{(STW-1){1'b0}}, 1'b1};
            if (step_ff == '0) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in   = diff;
            mag_in   = diff[CW] ? CW'(-diff) : diff[CW-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PRW'(mag_ff) * PRW'(steer_gain);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_data_in  = result;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      err_ff      <= err_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `DLCS_ASSERT(a_div_done, (state_ff == ST_DIV && step_ff == '0) |=> (state_ff == ST_ERR), "divider overran its step count")
   `DLCS_ASSERT(a_search_beat, (rsp_valid_ff && !rsp_data_ff.line_found) |-> (rsp_data_ff.linear_speed == '0 && rsp_data_ff.dark_count == '0), "search beat carries speed or count")
   `DLCS_ASSERT(a_fin_wait, (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FIN && $stable(rsp_data_ff)), "result overwritten while stalled")

endmodule

### sv/dark_line_centroid_steering_top.sv
// ----------------------------------------------------------------------------
// dark_line_centroid_steering_top
// Line-follower steering from a raster RGB pixel stream.
// Pixels arrive on the req_ channel as valid/ready beats, one per cycle, in
// raster order; the block tracks column and row from image_width/height.
// After the last pixel of each frame one beat leaves on the rsp_ channel with
// the dark-pixel centroid, error, count, forward speed and turn rate.
// Throughput: one pixel per cycle while the queue is not full. The frame ends
// are held in a two-entry queue; the back end takes one frame at a time (one
// quotient bit per cycle in the shift-subtract divider, then error, multiply
// and output), so req_ready falls only when two frames are waiting.
// A stall on rsp_ready holds the result register; the divider still works on
// the next frame and pixel intake goes on until the queue fills.
// Reset clears the position counters, accumulators and queue and restores
// all csr_ registers to their defaults. csr_ writes take effect at once and
// are meant for idle periods.
// ----------------------------------------------------------------------------
module dark_line_centroid_steering_top #(
   parameter int MAX_WIDTH  = dlcs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dlcs_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dlcs_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dlcs_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_we,
   input  logic [dlcs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dlcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int NW  = CW + RW + 1;
   localparam int SW  = NW + CW;
   localparam int DWW = (CW + 1 > 13) ? CW + 1 : 13;
   localparam int DHW = (RW + 1 > 13) ? RW + 1 : 13;

   logic [12:0]        image_width_ff, image_width_in;
   logic [12:0]        image_height_ff, image_height_in;
   logic [7:0]         dark_threshold_ff, dark_threshold_in;
   logic [15:0]        steer_gain_ff, steer_gain_in;
   logic [15:0]        forward_speed_ff, forward_speed_in;
   logic signed [15:0] search_turn_rate_ff, search_turn_rate_in;

   logic [DWW-1:0]     w_ext;
   logic [DHW-1:0]     h_ext;
   logic [CW:0]        w_eff;
   logic [RW:0]        h_eff;

   logic               push, pop, full, not_empty;
   logic [SW+NW-1:0]   push_data, pop_data;

   always_comb begin
      image_width_in      = image_width_ff;
      image_height_in     = image_height_ff;
      dark_threshold_in   = dark_threshold_ff;
      steer_gain_in       = steer_gain_ff;
      forward_speed_in    = forward_speed_ff;
      search_turn_rate_in = search_turn_rate_ff;
      if (csr_we) begin
         case (csr_index)
            dlcs_pkg::CSR_IMAGE_WIDTH:      image_width_in      = csr_wdata[12:0];
            dlcs_pkg::CSR_IMAGE_HEIGHT:     image_height_in     = csr_wdata[12:0];
            dlcs_pkg::CSR_DARK_THRESHOLD:   dark_threshold_in   = csr_wdata[7:0];
            dlcs_pkg::CSR_STEER_GAIN:       steer_gain_in       = csr_wdata;
            dlcs_pkg::CSR_FORWARD_SPEED:    forward_speed_in    = csr_wdata;
            dlcs_pkg::CSR_SEARCH_TURN_RATE: search_turn_rate_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff      <= dlcs_pkg::RST_IMAGE_WIDTH;
         image_height_ff     <= dlcs_pkg::RST_IMAGE_HEIGHT;
         dark_threshold_ff   <= dlcs_pkg::RST_DARK_THRESHOLD;
         steer_gain_ff       <= dlcs_pkg::RST_STEER_GAIN;
         forward_speed_ff    <= dlcs_pkg::RST_FORWARD_SPEED;
         search_turn_rate_ff <= dlcs_pkg::RST_SEARCH_TURN_RATE;
      end else begin
         image_width_ff      <= image_width_in;
         image_height_ff     <= image_height_in;
         dark_threshold_ff   <= dark_threshold_in;
         steer_gain_ff       <= steer_gain_in;
         forward_speed_ff    <= forward_speed_in;
         search_turn_rate_ff <= search_turn_rate_in;
      end
   end

   // zero reads as one, oversize as the maximum
   always_comb begin
      w_ext = DWW'(image_width_ff);
      h_ext = DHW'(image_height_ff);
      if (w_ext == '0) begin
         w_eff = (CW+1)'(1);
      end else if (w_ext > DWW'(MAX_WIDTH)) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = w_ext[CW:0];
      end
      if (h_ext == '0) begin
         h_eff = (RW+1)'(1);
      end else if (h_ext > DHW'(MAX_HEIGHT)) begin
         h_eff = (RW+1)'(MAX_HEIGHT);
      end else begin
         h_eff = h_ext[RW:0];
      end
   end

   dlcs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .w_eff          (w_eff),
      .h_eff          (h_eff),
      .dark_threshold (dark_threshold_ff),
      .full           (full),
      .push           (push),
      .push_data      (push_data)
   );

   dlcs_queue #(
      .DEPTH  (dlcs_pkg::QUEUE_DEPTH),
      .DATA_W (SW + NW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   dlcs_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (not_empty),
      .pop_data         (pop_data),
      .pop              (pop),
      .half_width       (w_eff[CW:1]),
      .steer_gain       (steer_gain_ff),
      .forward_speed    (forward_speed_ff),
      .search_turn_rate (search_turn_rate_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dark-line centroid steering block. Pixels go in
// as valid/ready beats. Each accepted beat is run through a local copy of the
// frame tracking and steering arithmetic, and every frame end queues the
// expected result. Each result beat is checked field by field against the
// oldest queued result. Directed frames cover the register extremes and a
// mid-frame resize. Random frames follow in three idling phases. A long
// result stall fills the block, and wide and tall frames close the run.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned RANDOM_BUDGET = 150;
   localparam int          LIMIT_WIDTH   = 96;
   localparam int          LIMIT_HEIGHT  = 64;

   localparam logic [dlcs_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [dlcs_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   dlcs_pkg::req_payload_type        req_payload = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   dlcs_pkg::rsp_payload_type        rsp_payload;
   logic                             csr_we = 1'b0;
   logic [dlcs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [dlcs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // register shadow
   logic [12:0] cfg_width     = dlcs_pkg::RST_IMAGE_WIDTH;
   logic [12:0] cfg_height    = dlcs_pkg::RST_IMAGE_HEIGHT;
   logic [7:0]  cfg_threshold = dlcs_pkg::RST_DARK_THRESHOLD;
   logic [15:0] cfg_gain      = dlcs_pkg::RST_STEER_GAIN;
   logic [15:0] cfg_speed     = dlcs_pkg::RST_FORWARD_SPEED;
   logic [15:0] cfg_turn      = dlcs_pkg::RST_SEARCH_TURN_RATE;

   // frame tracking
   int unsigned     pos_col = 0;
   int unsigned     pos_row = 0;
   longint unsigned col_sum = 0;
   longint unsigned dark_n  = 0;

   dlcs_pkg::rsp_payload_type steering_due[$];
   dlcs_pkg::rsp_payload_type steer_want;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_len     = 0;
   int unsigned stall_done    = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned mismatches    = 0;

   dark_line_centroid_steering_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic dlcs_pkg::req_payload_type rgb(input logic [7:0] r,
                                                     input logic [7:0] g,
                                                     input logic [7:0] b);
      return '{red: r, green: g, blue: b};
   endfunction

   // accumulate one pixel; queue the steering result on the last pixel of a frame
   function automatic void track_line_pixel(input dlcs_pkg::req_payload_type px);
      int unsigned     w, h, band_top;
      longint unsigned cen, mag, q;
      longint          err, err_sat, ang;
      bit              row_end;
      dlcs_pkg::rsp_payload_type res;
      w = (cfg_width == 0) ? 1 :
          (int'(cfg_width) > dlcs_pkg::MAX_WIDTH_DEF) ? dlcs_pkg::MAX_WIDTH_DEF :
          int'(cfg_width);
      h = (cfg_height == 0) ? 1 :
          (int'(cfg_height) > dlcs_pkg::MAX_HEIGHT_DEF) ? dlcs_pkg::MAX_HEIGHT_DEF :
          int'(cfg_height);
      band_top = (h * 3) / 4;
      if (pos_row >= band_top && pos_row < h && px.red < cfg_threshold &&
          px.green < cfg_threshold && px.blue < cfg_threshold) begin
         col_sum += pos_col;
         dark_n  += 1;
      end
      row_end = (pos_col + 1 >= w);
      if (!(row_end && pos_row + 1 >= h)) begin
         if (row_end) begin
            pos_col = 0;
            pos_row++;
         end else begin
            pos_col++;
         end
         return;
      end
      res = '0;
      if (dark_n > 0) begin
         cen = col_sum / dark_n;
         err = longint'(cen) - longint'(w / 2);
         mag = (err < 0) ? -err : err;
         q   = (mag * longint'(cfg_gain) + 8) >> 4;
         if (q > 8388608) q = 8388608;
         ang = (err > 0) ? -longint'(q) : longint'(q);
         if (ang > 8388607) ang = 8388607;
         err_sat = (err < -2048) ? -2048 : (err > 2047) ? 2047 : err;
         res.line_found   = 1'b1;
         res.centroid_x   = (cen > 4095) ? 12'hFFF : cen[11:0];
         res.offset_error = err_sat[11:0];
         res.dark_count   = (dark_n > 23'h7FFFFF) ? 23'h7FFFFF : dark_n[22:0];
         res.linear_speed = cfg_speed;
         res.angular_rate = ang[23:0];
      end else begin
         res.angular_rate = {{8{cfg_turn[15]}}, cfg_turn};
      end
      steering_due.push_back(res);
      pos_col = 0;
      pos_row = 0;
      col_sum = 0;
      dark_n  = 0;
   endfunction

   function automatic dlcs_pkg::req_payload_type pick_pixel();
      int unsigned thr, kind;
      logic [7:0]  ch [3];
      thr  = int'(cfg_threshold);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         if (thr != 0 && kind < 4) ch[i] = 8'($urandom_range(0, thr - 1));
         else if (thr != 0 && kind < 6) ch[i] = 8'(thr - $urandom_range(0, 1));
         else ch[i] = 8'($urandom);
      end
      return rgb(ch[0], ch[1], ch[2]);
   endfunction

   function automatic void compare_field(input string field, input longint want,
                                         input longint got);
      if (want != got) begin
         $display("%0t %s expected %0d actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_pixel(input dlcs_pkg::req_payload_type px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (!req_ready);
      track_line_pixel(px);
   endtask

   task automatic csr_write(input logic [dlcs_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dlcs_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         dlcs_pkg::CSR_IMAGE_WIDTH:      cfg_width     = data[12:0];
         dlcs_pkg::CSR_IMAGE_HEIGHT:     cfg_height    = data[12:0];
         dlcs_pkg::CSR_DARK_THRESHOLD:   cfg_threshold = data[7:0];
         dlcs_pkg::CSR_STEER_GAIN:       cfg_gain      = data;
         dlcs_pkg::CSR_FORWARD_SPEED:    cfg_speed     = data;
         dlcs_pkg::CSR_SEARCH_TURN_RATE: cfg_turn      = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // wait for every queued result, then for the back end to go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (steering_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_random_setup(output int unsigned frame_pixels);
      int unsigned w, h;
      logic [7:0]  thr;
      logic [15:0] gain, speed, turn;
      if ($urandom_range(0, 7) == 0) begin
         w = $urandom_range(7, 48);
         h = $urandom_range(1, 3);
      end else begin
         w = $urandom_range(0, 6);
         h = $urandom_range(0, 6);
      end
      case ($urandom_range(0, 5))
         0:       thr = 8'd0;
         1:       thr = 8'd255;
         default: thr = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       gain = 16'h0000;
         1:       gain = 16'hFFFF;
         default: gain = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       speed = 16'h0000;
         1:       speed = 16'hFFFF;
         default: speed = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       turn = 16'h8000;
         1:       turn = 16'h7FFF;
         default: turn = 16'($urandom);
      endcase
      csr_write(dlcs_pkg::CSR_IMAGE_WIDTH, {3'($urandom_range(0, 7)), 13'(w)});
      csr_write(dlcs_pkg::CSR_IMAGE_HEIGHT, {3'($urandom_range(0, 7)), 13'(h)});
      csr_write(dlcs_pkg::CSR_DARK_THRESHOLD, {8'($urandom), thr});
      csr_write(dlcs_pkg::CSR_STEER_GAIN, gain);
      csr_write(dlcs_pkg::CSR_FORWARD_SPEED, speed);
      csr_write(dlcs_pkg::CSR_SEARCH_TURN_RATE, turn);
      frame_pixels = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
   endtask

   // default registers, then a resize while the counters are mid-row
   task automatic test_mid_frame_resize();
      repeat (6) send_pixel(rgb(8'd0, 8'd0, 8'd0));
      settle();
      csr_write(dlcs_pkg::CSR_IMAGE_WIDTH, 16'd4);
      csr_write(dlcs_pkg::CSR_IMAGE_HEIGHT, 16'd4);
      send_pixel(rgb(8'd0, 8'd0, 8'd0));
      repeat (4) send_pixel(rgb(8'd0, 8'd0, 8'd0));
      repeat (4) send_pixel(rgb(8'd200, 8'd10, 8'd10));
      send_pixel(rgb(8'd0, 8'd0, 8'd0));
      send_pixel(rgb(8'd49, 8'd49, 8'd49));
      send_pixel(rgb(8'd50, 8'd0, 8'd0));
      send_pixel(rgb(8'd0, 8'd0, 8'd49));
   endtask

   task automatic test_register_extremes();
      settle();
      csr_write(dlcs_pkg::CSR_IMAGE_WIDTH, 16'hE000);
      csr_write(dlcs_pkg::CSR_IMAGE_HEIGHT, 16'h0000);
      send_pixel(rgb(8'd255, 8'd255, 8'd255));
      settle();
      csr_write(dlcs_pkg::CSR_SEARCH_TURN_RATE, 16'h8000);
      csr_write(dlcs_pkg::CSR_DARK_THRESHOLD, 16'hFF00);
      send_pixel(rgb(8'd0, 8'd0, 8'd0));
      settle();
      csr_write(dlcs_pkg::CSR_DARK_THRESHOLD, 16'h00FF);
      csr_write(dlcs_pkg::CSR_FORWARD_SPEED, 16'hFFFF);
      csr_write(dlcs_pkg::CSR_STEER_GAIN, 16'hFFFF);
      csr_write(dlcs_pkg::CSR_SEARCH_TURN_RATE, 16'h7FFF);
      send_pixel(rgb(8'd254, 8'd254, 8'd254));
      send_pixel(rgb(8'd255, 8'd254, 8'd254));
      send_pixel(rgb(8'd254, 8'd255, 8'd254));
      send_pixel(rgb(8'd254, 8'd254, 8'd255));
      settle();
      csr_write(CSR_SPARE_LO, 16'hFFFF);
      csr_write(CSR_SPARE_HI, 16'h0000);
      send_pixel(rgb(8'd0, 8'd0, 8'd0));
   endtask

   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned pixel_budget);
      int unsigned sent, frame_pixels, n;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < pixel_budget) begin
         settle();
         load_random_setup(frame_pixels);
         n = $urandom_range(1, 5) * frame_pixels;
         if ($urandom_range(0, 3) == 0) n += $urandom_range(0, frame_pixels - 1);
         repeat (n) send_pixel(pick_pixel());
         sent += n;
      end
      while (pos_col != 0 || pos_row != 0) send_pixel(pick_pixel());
   endtask

   // results held back long enough for the frame queue to fill and stall pixel intake
   task automatic test_result_backpressure();
      settle();
      csr_write(dlcs_pkg::CSR_IMAGE_WIDTH, 16'd2);
      csr_write(dlcs_pkg::CSR_IMAGE_HEIGHT, 16'd2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_len <= 300;
      repeat (80) send_pixel(pick_pixel());
   endtask

   // wide rows with the dark pixel at either edge; a tall single column last
   task automatic test_frame_limits();
      settle();
      csr_write(dlcs_pkg::CSR_IMAGE_WIDTH, 16'(LIMIT_WIDTH));
      csr_write(dlcs_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      csr_write(dlcs_pkg::CSR_DARK_THRESHOLD, 16'd128);
      csr_write(dlcs_pkg::CSR_STEER_GAIN, 16'hFFFF);
      for (int i = 0; i < LIMIT_WIDTH; i++)
         send_pixel(i == LIMIT_WIDTH - 1 ? rgb(8'd0, 8'd0, 8'd0) : rgb(8'd255, 8'd0, 8'd0));
      for (int i = 0; i < LIMIT_WIDTH; i++)
         send_pixel(i == 0 ? rgb(8'd127, 8'd127, 8'd127) : rgb(8'd0, 8'd0, 8'd128));
      settle();
      csr_write(dlcs_pkg::CSR_IMAGE_WIDTH, 16'd1);
      csr_write(dlcs_pkg::CSR_IMAGE_HEIGHT, 16'(LIMIT_HEIGHT));
      repeat (LIMIT_HEIGHT) send_pixel(pick_pixel());
   endtask

   always @(posedge clock) begin
      if (stall_done < stall_len) begin
         rsp_ready  <= 1'b0;
         stall_done <= stall_done + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (steering_due.size() == 0) begin
            $display("%0t result beat with no frame pending", $time);
            mismatches++;
         end else begin
            steer_want = steering_due.pop_front();
            compare_field("line_found", longint'(steer_want.line_found),
                          longint'(rsp_payload.line_found));
            compare_field("centroid_x", longint'(steer_want.centroid_x),
                          longint'(rsp_payload.centroid_x));
            compare_field("offset_error", longint'(steer_want.offset_error),
                          longint'(rsp_payload.offset_error));
            compare_field("dark_count", longint'(steer_want.dark_count),
                          longint'(rsp_payload.dark_count));
            compare_field("linear_speed", longint'(steer_want.linear_speed),
                          longint'(rsp_payload.linear_speed));
            compare_field("angular_rate", longint'(steer_want.angular_rate),
                          longint'(rsp_payload.angular_rate));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("** dark_line_centroid_steering_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 13;
      recv_idle_pct = 69;
      test_mid_frame_resize();
      test_register_extremes();
      test_random_traffic(13, 69, RANDOM_BUDGET);
      test_random_traffic(69, 13, RANDOM_BUDGET);
      test_random_traffic(0, 0, RANDOM_BUDGET);
      test_result_backpressure();
      test_frame_limits();
      settle();
      if (mismatches == 0) begin
         $display("** dark_line_centroid_steering_top: PASSED **");
      end else begin
         $display("** dark_line_centroid_steering_top: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/dlcs_pkg.sv
sv/dlcs_front.sv
sv/dlcs_queue.sv
sv/dlcs_back.sv
sv/dark_line_centroid_steering_top.sv
bench/testbench.sv
